// ----- src/assert_macros.svh -----
// Clocked assertion helpers, disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

// ----- src/isbar_pkg.sv -----
package isbar_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIXEL_BITS = 8;
    localparam int DIM_BITS   = 11;
    localparam int POS_BITS   = 10;
    localparam int COORD_BITS = 12;
    localparam int SUM_BITS   = 12;
    localparam int HSUM_BITS  = 10;
    localparam int SUMS_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_BITS  = $clog2(SUMS_DEPTH);
    localparam int CNT_BITS   = 4;

    typedef enum logic [1:0] {
        MODE_QUARTER = 2'd0,
        MODE_HALF    = 2'd1,
        MODE_DOUBLE  = 2'd2,
        MODE_QUAD    = 2'd3
    } scale_mode_t;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_SCALE_MODE   = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [DIM_BITS-1:0]   dim_t;
    typedef logic [POS_BITS-1:0]   pos_t;

    localparam dim_t RESET_WIDTH  = dim_t'(640);
    localparam dim_t RESET_HEIGHT = dim_t'(480);
    localparam dim_t MAX_W_DIM    = dim_t'(MAX_WIDTH);
    localparam dim_t MAX_H_DIM    = dim_t'(MAX_HEIGHT);

endpackage

// ----- src/isbar_pixel_if.sv -----
interface isbar_pixel_if;
    import isbar_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

// ----- src/isbar_result_if.sv -----
interface isbar_result_if;
    import isbar_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t pixel_out;
    coord_t target_row;
    coord_t target_col;
    logic   run_last;

    modport source (output valid, output pixel_out, output target_row,
                    output target_col, output run_last, input ready);
    modport sink   (input valid, input pixel_out, input target_row,
                    input target_col, input run_last, output ready);
endinterface

// ----- src/image_scale_box_average_replicate.sv -----
// Channel   | Dir | Item
// ----------+-----+-------------------------------------------------
// pixels    | in  | pixel_in: one grey source pixel, raster order
// results   | out | pixel_out, target_row, target_col, run_last
// cfg_*     | in  | register write: cfg_index selects, cfg_data value
//
// Quarter and half size take one item per cycle unless a window end meets a
// stall; double and quadruple size send 4 and 16 results per item from the
// result register, one per cycle while results.ready is high, after the input
// stage. Reset is immediate: every window sum is written before it is read, so
// the line store needs no clearing pass. A stalled result holds; one more item
// waits in the input stage, and the next is taken when that stage moves.
`include "assert_macros.svh"

module image_scale_box_average_replicate (
    input  logic                       clk,
    input  logic                       rst_n,
    isbar_pixel_if.sink                pixels,
    isbar_result_if.source             results,
    input  logic                       cfg_write,
    input  isbar_pkg::reg_index_t      cfg_index,
    input  logic [isbar_pkg::DIM_BITS-1:0] cfg_data
);
    import isbar_pkg::*;

    dim_t        width_reg;
    dim_t        height_reg;
    scale_mode_t mode_reg;
    pos_t        col_reg;
    pos_t        row_reg;

    logic                  s1_valid_reg;
    pixel_t                s1_pix_reg;
    pos_t                  s1_row_reg;
    pos_t                  s1_col_reg;
    logic                  s1_inreg_reg;
    logic                  s1_hfirst_reg;
    logic                  s1_hlast_reg;
    logic                  s1_vfirst_reg;
    logic                  s1_vlast_reg;
    logic [ADDR_BITS-1:0]  s1_addr_reg;
    logic [HSUM_BITS-1:0]  hacc_reg;

    logic [SUM_BITS-1:0]   sums_mem [SUMS_DEPTH];
    logic [SUM_BITS-1:0]   mem_rd_reg;

    logic                  out_valid_reg;
    pixel_t                out_pix_reg;
    coord_t                out_row_reg;
    coord_t                out_col_reg;
    logic [CNT_BITS-1:0]   out_cnt_reg;
    logic [CNT_BITS-1:0]   out_last_cnt_reg;
    logic                  out_win4_reg;

    dim_t                  w_eff;
    dim_t                  h_eff;
    logic                  win4;
    logic                  down;
    logic                  wrap;
    pos_t                  c_cur;
    pos_t                  r_cur;
    dim_t                  c_inc;
    dim_t                  r_inc;
    dim_t                  full_c;
    dim_t                  full_r;
    logic                  in_fire;
    logic                  mem_re;
    logic [ADDR_BITS-1:0]  rd_addr;

    logic [HSUM_BITS-1:0]  hsum;
    logic [SUM_BITS-1:0]   total;
    logic [SUM_BITS:0]     rounded;
    pixel_t                avg;
    logic                  s1_emit;
    logic                  s1_fire;
    logic                  mem_we;
    logic                  out_take;
    logic                  out_last;
    logic                  out_free;
    logic [1:0]            ii;
    logic [1:0]            jj;

    assign w_eff = (width_reg == '0) ? dim_t'(1) :
                   (width_reg > MAX_W_DIM) ? MAX_W_DIM : width_reg;
    assign h_eff = (height_reg == '0) ? dim_t'(1) :
                   (height_reg > MAX_H_DIM) ? MAX_H_DIM : height_reg;
    assign win4  = (mode_reg == MODE_QUARTER) || (mode_reg == MODE_QUAD);
    assign down  = (mode_reg == MODE_QUARTER) || (mode_reg == MODE_HALF);

    assign wrap  = ({1'b0, row_reg} >= h_eff) || ({1'b0, col_reg} >= w_eff);
    assign c_cur = wrap ? '0 : col_reg;
    assign r_cur = wrap ? '0 : row_reg;
    assign c_inc = {1'b0, c_cur} + dim_t'(1);
    assign r_inc = {1'b0, r_cur} + dim_t'(1);
    assign full_c = win4 ? {w_eff[DIM_BITS-1:2], 2'b00} : {w_eff[DIM_BITS-1:1], 1'b0};
    assign full_r = win4 ? {h_eff[DIM_BITS-1:2], 2'b00} : {h_eff[DIM_BITS-1:1], 1'b0};

    // input stage moves when it has no result to send or the result register frees
    assign out_last = out_valid_reg && (out_cnt_reg == out_last_cnt_reg);
    assign out_take = out_valid_reg && results.ready;
    assign out_free = !out_valid_reg || (results.ready && out_last);
    assign s1_fire  = s1_valid_reg && (!s1_emit || out_free);
    assign pixels.ready = !s1_valid_reg || s1_fire;
    assign in_fire  = pixels.valid && pixels.ready;

    assign rd_addr = win4 ? ADDR_BITS'(c_cur[POS_BITS-1:2]) : c_cur[POS_BITS-1:1];
    assign mem_re  = in_fire && down &&
                     (win4 ? (c_cur[1:0] == 2'd3) : c_cur[0]);

    assign hsum    = s1_hfirst_reg ? HSUM_BITS'(s1_pix_reg)
                                   : hacc_reg + HSUM_BITS'(s1_pix_reg);
    assign total   = (s1_vfirst_reg ? '0 : mem_rd_reg) + SUM_BITS'(hsum);
    assign rounded = {1'b0, total} + (win4 ? (SUM_BITS+1)'(8) : (SUM_BITS+1)'(2));
    assign avg     = win4 ? rounded[11:4] : rounded[9:2];
    assign s1_emit = down ? (s1_inreg_reg && s1_hlast_reg && s1_vlast_reg) : 1'b1;
    assign mem_we  = s1_fire && down && s1_inreg_reg && s1_hlast_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sums_mem[s1_addr_reg] <= total;
        end
        if (mem_re)
        begin
            mem_rd_reg <= sums_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= RESET_WIDTH;
            height_reg    <= RESET_HEIGHT;
            mode_reg      <= MODE_HALF;
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index != REG_UNUSED))
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    REG_SCALE_MODE:   mode_reg   <= scale_mode_t'(cfg_data[1:0]);
                    default:          ;
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (in_fire)
            begin
                if (c_inc >= w_eff)
                begin
                    col_reg <= '0;
                    row_reg <= (r_inc >= h_eff) ? '0 : r_inc[POS_BITS-1:0];
                end
                else
                begin
                    col_reg <= c_inc[POS_BITS-1:0];
                end
            end

            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire && s1_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take && out_last)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg    <= pixels.pixel_in;
            s1_row_reg    <= r_cur;
            s1_col_reg    <= c_cur;
            s1_inreg_reg  <= ({1'b0, c_cur} < full_c) && ({1'b0, r_cur} < full_r);
            s1_hfirst_reg <= win4 ? (c_cur[1:0] == 2'd0) : !c_cur[0];
            s1_hlast_reg  <= win4 ? (c_cur[1:0] == 2'd3) : c_cur[0];
            s1_vfirst_reg <= win4 ? (r_cur[1:0] == 2'd0) : !r_cur[0];
            s1_vlast_reg  <= win4 ? (r_cur[1:0] == 2'd3) : r_cur[0];
            s1_addr_reg   <= rd_addr;
        end
        if (s1_fire && down && s1_inreg_reg)
        begin
            hacc_reg <= hsum;
        end
        if (s1_fire && s1_emit)
        begin
            out_cnt_reg  <= '0;
            out_win4_reg <= win4;
            if (down)
            begin
                out_pix_reg      <= avg;
                out_row_reg      <= win4 ? coord_t'(s1_row_reg[POS_BITS-1:2])
                                         : coord_t'(s1_row_reg[POS_BITS-1:1]);
                out_col_reg      <= win4 ? coord_t'(s1_col_reg[POS_BITS-1:2])
                                         : coord_t'(s1_col_reg[POS_BITS-1:1]);
                out_last_cnt_reg <= '0;
            end
            else
            begin
                out_pix_reg      <= s1_pix_reg;
                out_row_reg      <= win4 ? {s1_row_reg, 2'b00} : {1'b0, s1_row_reg, 1'b0};
                out_col_reg      <= win4 ? {s1_col_reg, 2'b00} : {1'b0, s1_col_reg, 1'b0};
                out_last_cnt_reg <= win4 ? CNT_BITS'(15) : CNT_BITS'(3);
            end
        end
        else if (out_take && !out_last)
        begin
            out_cnt_reg <= out_cnt_reg + CNT_BITS'(1);
        end
    end

    assign jj = out_win4_reg ? out_cnt_reg[1:0] : {1'b0, out_cnt_reg[0]};
    assign ii = out_win4_reg ? out_cnt_reg[3:2] : {1'b0, out_cnt_reg[1]};

    assign results.valid      = out_valid_reg;
    assign results.pixel_out  = out_pix_reg;
    assign results.target_row = out_row_reg + coord_t'(ii);
    assign results.target_col = out_col_reg + coord_t'(jj);
    assign results.run_last   = out_cnt_reg == out_last_cnt_reg;

    `ASSERT_CLK(a_down_single, clk, rst_n, results.valid && down |-> results.run_last)
    `ASSERT_CLK(a_accept_loads, clk, rst_n, in_fire |=> s1_valid_reg)
    `ASSERT_CLK(a_cnt_bound, clk, rst_n, out_valid_reg |-> out_cnt_reg <= out_last_cnt_reg)
    `ASSERT_NEVER(a_no_rw_clash, clk, rst_n, mem_we && mem_re && (s1_addr_reg == rd_addr))

endmodule

// ----- dv/image_scale_box_average_replicate_tb.sv -----
`timescale 1ns / 1ps

module image_scale_box_average_replicate_tb;
    import isbar_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct packed {
        pixel_t pixel;
        coord_t row;
        coord_t col;
        logic   last;
    } target_pixel_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    reg_index_t cfg_index;
    dim_t       cfg_data;

    isbar_pixel_if  pixel_ch ();
    isbar_result_if result_ch ();

    image_scale_box_average_replicate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixel_ch),
        .results   (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pixel_t        source_pixels[$];
    target_pixel_t target_pixels_due[$];

    dim_t          width_reg  = RESET_WIDTH;
    dim_t          height_reg = RESET_HEIGHT;
    scale_mode_t   mode_reg   = MODE_HALF;
    logic [11:0]   column_sums [SUMS_DEPTH];
    int unsigned   next_col = 0;
    int unsigned   next_row = 0;

    bit            sender_idles   = 1'b1;
    bit            receiver_idles = 1'b1;
    bit            pressure_armed = 1'b0;
    bit            pressure_done;
    int unsigned   hold_left;
    int unsigned   send_gap;
    int unsigned   stall_left;
    int unsigned   cycle_count      = 0;
    int unsigned   mismatches       = 0;
    int unsigned   pixels_accepted  = 0;
    int unsigned   results_checked  = 0;
    int unsigned   settings_used    = 0;

    function automatic int unsigned effective_dim(dim_t v, int unsigned hi);
        if (v == 0)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic void apply_register(reg_index_t idx, dim_t data);
        case (idx)
            REG_IMAGE_WIDTH:  width_reg = data;
            REG_IMAGE_HEIGHT: height_reg = data;
            REG_SCALE_MODE:   mode_reg = scale_mode_t'(data[1:0]);
            default:          return;
        endcase
        next_col = 0;
        next_row = 0;
    endfunction

    function automatic void scale_source_pixel(pixel_t p);
        int unsigned   w;
        int unsigned   h;
        int unsigned   r;
        int unsigned   c;
        int unsigned   win;
        int unsigned   idx;
        int unsigned   area;
        target_pixel_t t;
        w = effective_dim(width_reg, MAX_WIDTH);
        h = effective_dim(height_reg, MAX_HEIGHT);
        r = next_row;
        c = next_col;
        win = (mode_reg == MODE_QUARTER || mode_reg == MODE_QUAD) ? 4 : 2;
        if (r >= h || c >= w)
        begin
            r = 0;
            c = 0;
        end
        if (mode_reg == MODE_QUARTER || mode_reg == MODE_HALF)
        begin
            if (c < (w / win) * win && r < (h / win) * win)
            begin
                idx = c / win;
                if (r % win == 0 && c % win == 0)
                begin
                    column_sums[idx] = 12'(p);
                end
                else
                begin
                    column_sums[idx] = column_sums[idx] + 12'(p);
                end
                if (r % win == win - 1 && c % win == win - 1)
                begin
                    area = win * win;
                    t.pixel = pixel_t'((column_sums[idx] + area / 2) / area);
                    t.row   = coord_t'(r / win);
                    t.col   = coord_t'(c / win);
                    t.last  = 1'b1;
                    target_pixels_due.push_back(t);
                end
            end
        end
        else
        begin
            for (int unsigned ii = 0; ii < win; ii++)
            begin
                for (int unsigned jj = 0; jj < win; jj++)
                begin
                    t.pixel = p;
                    t.row   = coord_t'(r * win + ii);
                    t.col   = coord_t'(c * win + jj);
                    t.last  = (ii == win - 1 && jj == win - 1);
                    target_pixels_due.push_back(t);
                end
            end
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
            begin
                r = 0;
            end
        end
        next_col = c;
        next_row = r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // source side: hold the item until taken, then wait the drawn gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_ch.valid    <= 1'b0;
            pixel_ch.pixel_in <= '0;
            send_gap          <= 0;
        end
        else if (!pixel_ch.valid || pixel_ch.ready)
        begin
            if (send_gap != 0)
            begin
                send_gap       <= send_gap - 1;
                pixel_ch.valid <= 1'b0;
            end
            else if (source_pixels.size() != 0)
            begin
                pixel_ch.pixel_in <= source_pixels.pop_front();
                pixel_ch.valid    <= 1'b1;
                send_gap          <= sender_idles ? $urandom_range(0, 10) : 0;
            end
            else
            begin
                pixel_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left     <= 0;
            pressure_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (pressure_armed && !pressure_done && result_ch.valid)
        begin
            hold_left     <= HOLD_CYCLES;
            pressure_done <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver
        int unsigned stall;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
        end
        else if (hold_left != 0)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (result_ch.valid && result_ch.ready)
        begin
            stall = receiver_idles ? $urandom_range(0, 10) : 0;
            stall_left      <= stall;
            result_ch.ready <= (stall == 0);
        end
        else if (stall_left != 0)
        begin
            stall_left      <= stall_left - 1;
            result_ch.ready <= (stall_left == 1);
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : monitor
        target_pixel_t due;
        if (rst_n)
        begin
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                scale_source_pixel(pixel_ch.pixel_in);
                pixels_accepted++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                results_checked++;
                if (target_pixels_due.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected target pixel %0d at row %0d col %0d",
                                 result_ch.pixel_out, result_ch.target_row,
                                 result_ch.target_col);
                    end
                    mismatches++;
                end
                else
                begin
                    due = target_pixels_due.pop_front();
                    if (result_ch.pixel_out !== due.pixel || result_ch.target_row !== due.row
                        || result_ch.target_col !== due.col
                        || result_ch.run_last !== due.last)
                    begin
                        if (mismatches < 10)
                        begin
                            $display({"mismatch: expected pix %0d row %0d col %0d last %0b,",
                                      " got pix %0d row %0d col %0d last %0b"},
                                     due.pixel, due.row, due.col, due.last,
                                     result_ch.pixel_out, result_ch.target_row,
                                     result_ch.target_col, result_ch.run_last);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic write_reg(reg_index_t idx, dim_t data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        apply_register(idx, data);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(scale_mode_t mode, dim_t w, dim_t h);
        write_reg(REG_SCALE_MODE, dim_t'(mode));
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        settings_used++;
    endtask

    // drain pending items and expected results, then let the pipeline empty
    task automatic settle();
        do
            @(negedge clk);
        while (source_pixels.size() != 0 || pixel_ch.valid || target_pixels_due.size() != 0);
        repeat (6) @(negedge clk);
    endtask

    function automatic pixel_t random_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return pixel_t'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin : stimulus
        scale_mode_t mode;
        dim_t        w;
        dim_t        h;
        int unsigned win;
        int unsigned count;
        int unsigned random_items;
        int unsigned phase;
        random_items = 0;
        phase        = 0;
        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = REG_IMAGE_WIDTH;
        cfg_data           = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        source_pixels.push_back(8'd0);
        source_pixels.push_back(8'd255);
        source_pixels.push_back(8'hAA);
        settle();

        // unused index must not restart the window
        configure(MODE_HALF, 11'd2, 11'd2);
        source_pixels.push_back(8'd1);
        source_pixels.push_back(8'd0);
        settle();
        write_reg(REG_UNUSED, 11'h7FF);
        source_pixels.push_back(8'd0);
        source_pixels.push_back(8'd1);
        settle();

        configure(MODE_QUARTER, 11'd4, 11'd4);
        repeat (16) source_pixels.push_back(8'd255);
        settle();

        configure(MODE_DOUBLE, 11'd0, 11'd0);
        source_pixels.push_back(8'h55);
        source_pixels.push_back(8'hFF);
        settle();

        configure(MODE_QUAD, 11'h7FF, 11'h7FF);
        source_pixels.push_back(8'h80);
        source_pixels.push_back(8'h7F);
        settle();

        while (random_items < 120)
        begin
            mode = scale_mode_t'(phase % 4);
            phase++;
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            if (mode == MODE_QUARTER || mode == MODE_HALF)
            begin
                win = (mode == MODE_QUARTER) ? 4 : 2;
                if ($urandom_range(0, 2) != 0)
                begin
                    w = dim_t'(win * $urandom_range(1, (mode == MODE_QUARTER) ? 2 : 4));
                    h = dim_t'(win * $urandom_range(1, (mode == MODE_QUARTER) ? 1 : 2));
                end
                else
                begin
                    w = dim_t'($urandom_range(0, 9));
                    h = dim_t'($urandom_range(0, 5));
                end
                count = effective_dim(w, MAX_WIDTH) * effective_dim(h, MAX_HEIGHT)
                        + $urandom_range(0, effective_dim(w, MAX_WIDTH));
            end
            else
            begin
                w = dim_t'($urandom_range(0, 6));
                h = dim_t'($urandom_range(1, 4));
                if ($urandom_range(0, 4) == 0)
                begin
                    w = dim_t'($urandom_range(1000, 2047));
                end
                count = $urandom_range(3, 10);
            end
            configure(mode, w, h);
            repeat (count) source_pixels.push_back(random_pixel());
            random_items += count;
            settle();
        end

        // stall the output long enough to back up the input
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        configure(MODE_QUAD, 11'd5, 11'd3);
        pressure_armed = 1'b1;
        repeat (12) source_pixels.push_back(random_pixel());
        settle();

        repeat (20) @(negedge clk);
        mismatches += target_pixels_due.size();
        $display("Scaled %0d source pixels into %0d target pixels across %0d register settings",
                 pixels_accepted, results_checked, settings_used);
        $display("Covered all four scale modes, clamped and saturated sizes and a long output stall");
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/isbar_pkg.sv
src/isbar_pixel_if.sv
src/isbar_result_if.sv
src/image_scale_box_average_replicate.sv
dv/image_scale_box_average_replicate_tb.sv
